FILE: hdl/rbd_pkg.sv
// rbd_pkg: shared types, constants and lookup functions for the rtty bit slicer
// and baudot decoder. no dependencies; imported by every module of the block.
`default_nettype none
package rbd_pkg;

  localparam int unsigned FracBits  = 12;
  localparam int unsigned FrameBits = 8;
  localparam int unsigned StopBits  = FrameBits - 6;
  localparam int unsigned HistBits  = 16;
  localparam int unsigned MaxRun    = 16;
  localparam int unsigned CfgW      = 15;
  localparam int unsigned TickW     = 32;
  localparam int unsigned FifoDepth = 2;

  // register indexes
  localparam logic [1:0] RegGain   = 2'd0;
  localparam logic [1:0] RegDecay  = 2'd1;
  localparam logic [1:0] RegPeriod = 2'd2;
  localparam logic [1:0] RegSwitch = 2'd3;

  // shift control characters
  localparam logic [7:0] ChFigs = 8'h84;
  localparam logic [7:0] ChLtrs = 8'h85;

  typedef struct packed {
    logic [CfgW-1:0] gain;
    logic [CfgW-1:0] decay;
    logic [CfgW-1:0] period;
    logic [CfgW-1:0] switch_dly;
  } cfg_t;

  // one finished tone run handed from front to back
  typedef struct packed {
    logic             mark;
    logic [TickW-1:0] ticks;
  } run_t;

  typedef struct packed {
    logic       fig;
    logic [7:0] ch;
    logic [4:0] code;
  } result_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_SUM, F_TONE, F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV, B_SHIFT, B_SCAN, B_EMIT
  } back_state_e;

  function automatic logic [4:0] rev5(input logic [4:0] v);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) begin
      r[4-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] letters_char(input logic [4:0] c);
    logic [7:0] r;
    unique case (c)
      5'd0:  r = 8'h80;  5'd1:  r = 8'h45;  5'd2:  r = 8'h81;  5'd3:  r = 8'h41;
      5'd4:  r = 8'h82;  5'd5:  r = 8'h53;  5'd6:  r = 8'h49;  5'd7:  r = 8'h55;
      5'd8:  r = 8'h83;  5'd9:  r = 8'h44;  5'd10: r = 8'h52;  5'd11: r = 8'h4A;
      5'd12: r = 8'h4E;  5'd13: r = 8'h46;  5'd14: r = 8'h43;  5'd15: r = 8'h4B;
      5'd16: r = 8'h54;  5'd17: r = 8'h5A;  5'd18: r = 8'h4C;  5'd19: r = 8'h57;
      5'd20: r = 8'h48;  5'd21: r = 8'h59;  5'd22: r = 8'h50;  5'd23: r = 8'h51;
      5'd24: r = 8'h4F;  5'd25: r = 8'h42;  5'd26: r = 8'h47;  5'd27: r = 8'h84;
      5'd28: r = 8'h4D;  5'd29: r = 8'h58;  5'd30: r = 8'h56;  5'd31: r = 8'h85;
      default: r = 8'h80;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] figures_char(input logic [4:0] c);
    logic [7:0] r;
    unique case (c)
      5'd0:  r = 8'h80;  5'd1:  r = 8'h33;  5'd2:  r = 8'h81;  5'd3:  r = 8'h2D;
      5'd4:  r = 8'h82;  5'd5:  r = 8'h27;  5'd6:  r = 8'h38;  5'd7:  r = 8'h37;
      5'd8:  r = 8'h83;  5'd9:  r = 8'h86;  5'd10: r = 8'h34;  5'd11: r = 8'h87;
      5'd12: r = 8'h2C;  5'd13: r = 8'h21;  5'd14: r = 8'h3A;  5'd15: r = 8'h28;
      5'd16: r = 8'h35;  5'd17: r = 8'h22;  5'd18: r = 8'h29;  5'd19: r = 8'h32;
      5'd20: r = 8'h23;  5'd21: r = 8'h36;  5'd22: r = 8'h30;  5'd23: r = 8'h31;
      5'd24: r = 8'h39;  5'd25: r = 8'h3F;  5'd26: r = 8'h26;  5'd27: r = 8'h84;
      5'd28: r = 8'h2E;  5'd29: r = 8'h2F;  5'd30: r = 8'h3B;  5'd31: r = 8'h85;
      default: r = 8'h80;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rtty_bit_slicer_baudot_decoder.sv
// rtty_bit_slicer_baudot_decoder: top level, configuration registers and the
// front / queue / back split. depends on rbd_pkg, rbd_front, rbd_fifo, rbd_back.
//
// usage:
//   s_axis carries one discriminator sample and the ticks since the last one.
//   m_axis carries zero, one or two decoded characters per sample; tlast marks
//   the final character caused by that sample.
//   cfg_we_i writes register cfg_idx_i (0 gain, 1 decay, 2 bit period,
//   3 switch delay) from cfg_data_i in the same cycle; write only when idle.
// timing:
//   the front takes a sample through multiply, sum, tone check and push; a
//   sample that ends a tone run hands the run to a 2-deep queue. the back
//   then rounds it to a bit count capped at 16 (one period subtraction per
//   cycle), shifts it into the bit history, scans for frames and moves each
//   character into the output register.
//   sustained rate is therefore set by the back divider and frame scan.
// reset: filter level, run counters, bit history and shift state clear, tone
//   is mark, registers return to 1024 / 3072 / 4400 / 1100.
// stalls: a held m_axis word stops the back; the queue keeps the front taking
//   samples until it fills, then a sample that ends a run holds s_axis_tready low.
`default_nettype none
module rtty_bit_slicer_baudot_decoder import rbd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [14:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // sample[15:0], elapsed_ticks[31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // baudot_code[4:0], char_code[12:5],
                                           // figures_shift[13], zero[15:14]
  output logic             m_axis_tlast
);

  cfg_t    cfg_q;
  logic    push, full, pop, empty;
  run_t    push_data, pop_data;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain       <= 15'd1024;
      cfg_q.decay      <= 15'd3072;
      cfg_q.period     <= 15'd4400;
      cfg_q.switch_dly <= 15'd1100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegGain:   cfg_q.gain       <= cfg_data_i;
        RegDecay:  cfg_q.decay      <= cfg_data_i;
        RegPeriod: cfg_q.period     <= cfg_data_i;
        RegSwitch: cfg_q.switch_dly <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata[15:0]),
    .ticks_i     (s_axis_tdata[31:16]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  rbd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  rbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .run_i       (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, res.fig, res.ch, res.code};

endmodule
`default_nettype wire

FILE: hdl/rbd_front.sv
// rbd_front: one-pole filter, mark/space slicer and tone-change timing.
// depends on rbd_pkg; pushes finished runs into rbd_fifo.
`default_nettype none
module rbd_front import rbd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sample_i,
  input  wire logic [15:0] ticks_i,
  output logic             push_o,
  output run_t             push_data_o,
  input  wire logic        full_i
);

  front_state_e state_q, state_d;

  logic signed [15:0] x_q;
  logic [15:0]        ticks_q;
  logic signed [31:0] prod_a_q, prod_b_q;
  logic signed [15:0] level_q;
  logic               tone_q;   // 1 = mark
  logic [TickW-1:0]   pend_q, mark_q, space_q, pend_new_q;
  logic               same_q, trans_q;

  logic signed [31:0] sum;
  logic signed [15:0] level_sat;
  logic               cur_mark;
  logic [TickW:0]     pend_add;
  logic [TickW-1:0]   pend_sat;
  logic [TickW-1:0]   cur_cnt, old_cnt, d_ticks, run_len;
  logic [TickW:0]     cnt_add;
  logic [TickW-1:0]   cnt_sat;

  always_comb begin
    sum = (prod_a_q >>> FracBits) + (prod_b_q >>> FracBits);
    if (sum > 32'sd32767) begin
      level_sat = 16'sh7FFF;
    end else if (sum < -32'sd32768) begin
      level_sat = 16'sh8000;
    end else begin
      level_sat = sum[15:0];
    end
    cur_mark = level_q[15] || (level_q == 16'sd0);
    pend_add = {1'b0, pend_q} + {{(TickW-15){1'b0}}, ticks_q};
    pend_sat = pend_add[TickW] ? '1 : pend_add[TickW-1:0];
    cur_cnt  = tone_q ? mark_q : space_q;
    cnt_add  = {1'b0, cur_cnt} + {{(TickW-15){1'b0}}, ticks_q};
    cnt_sat  = cnt_add[TickW] ? '1 : cnt_add[TickW-1:0];
    // the run that ends is the old tone's count less the pending time
    old_cnt  = cur_cnt;
    d_ticks  = pend_new_q - {{(TickW-16){1'b0}}, ticks_q};
    run_len  = (old_cnt > d_ticks) ? old_cnt - d_ticks : '0;
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    push_data_o = '{mark: tone_q, ticks: run_len};
    unique case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = F_MUL;
      end
      F_MUL:  state_d = F_SUM;
      F_SUM:  state_d = F_TONE;
      F_TONE: state_d = F_PUSH;
      F_PUSH: begin
        if (!trans_q) begin
          state_d = F_IDLE;
        end else if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      level_q <= '0;
      tone_q  <= 1'b1;
      pend_q  <= '0;
      mark_q  <= '0;
      space_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_SUM) level_q <= level_sat;
      if (state_q == F_PUSH) begin
        if (trans_q) begin
          if (!full_i) begin
            tone_q <= ~tone_q;
            pend_q <= '0;
            if (tone_q) begin
              mark_q  <= '0;
              space_q <= pend_new_q;
            end else begin
              space_q <= '0;
              mark_q  <= pend_new_q;
            end
          end
        end else begin
          pend_q <= same_q ? '0 : pend_new_q;
          if (tone_q) mark_q <= cnt_sat;
          else        space_q <= cnt_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      x_q     <= sample_i;
      ticks_q <= ticks_i;
    end
    if (state_q == F_MUL) begin
      prod_a_q <= $signed({1'b0, cfg_i.gain}) * x_q;
      prod_b_q <= $signed({1'b0, cfg_i.decay}) * level_q;
    end
    if (state_q == F_TONE) begin
      pend_new_q <= pend_sat;
      same_q     <= (cur_mark == tone_q);
      trans_q    <= (cur_mark != tone_q) &&
                    (pend_sat > {{(TickW-CfgW){1'b0}}, cfg_i.switch_dly});
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rbd_fifo.sv
// rbd_fifo: short run queue between the front and the back.
// depends on rbd_pkg for run_t and the depth.
`default_nettype none
module rbd_fifo import rbd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire run_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output run_t      pop_data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  run_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rbd_back.sv
// rbd_back: rounds runs to bit counts, keeps the bit history, frames and
// translates characters, drives the result register. depends on rbd_pkg.
`default_nettype none
module rbd_back import rbd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     empty_i,
  input  wire run_t     run_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output result_t       out_res_o,
  output logic          out_last_o
);

  back_state_e state_q, state_d;

  logic [TickW-1:0]    rem_q;
  logic [4:0]          n_q;
  logic                one_q;
  logic [HistBits-1:0] hist_q;
  logic [4:0]          held_q;
  logic                fig_q;
  logic [1:0]          cnt_q;
  logic                idx_q;
  result_t             res_q [2];
  logic                m_valid_q, m_last_q;
  result_t             m_res_q;

  logic [CfgW-1:0]     period;
  logic [CfgW-1:0]     half;
  logic [31:0]         shifted, fill;
  logic [5:0]          held_sum;
  logic [3:0]          over;
  logic [HistBits-1:0] win_full;
  logic [FrameBits-1:0] win;
  logic                frame_ok, scan_go;
  logic [4:0]          code;
  logic [7:0]          ch;
  logic                out_free;

  always_comb begin
    period   = (cfg_i.period == '0) ? CfgW'(1) : cfg_i.period;
    half     = period >> 1;
    fill     = one_q ? ((32'd1 << n_q) - 32'd1) : 32'd0;
    shifted  = ({16'd0, hist_q} << n_q) | fill;
    held_sum = {1'b0, held_q} + {1'b0, n_q};
    over     = 4'(held_q - 5'(FrameBits));
    win_full = hist_q >> over;
    win      = win_full[FrameBits-1:0];
    frame_ok = (&win[StopBits-1:0]) && !win[FrameBits-1];
    scan_go  = (held_q >= 5'(FrameBits)) && (cnt_q != 2'd2);
    code     = rev5(win[FrameBits-2 -: 5]);
    ch       = fig_q ? figures_char(code) : letters_char(code);
    out_free = !m_valid_q || out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = (run_i.ticks <= {{(TickW-CfgW){1'b0}}, half}) ? B_SHIFT : B_DIV;
        end
      end
      B_DIV: begin
        if (n_q == 5'(MaxRun)) state_d = B_SHIFT;
        else if (rem_q <= {{(TickW-CfgW){1'b0}}, period}) state_d = B_SHIFT;
      end
      B_SHIFT: state_d = B_SCAN;
      B_SCAN: begin
        if (!scan_go) state_d = (cnt_q == 2'd0) ? B_IDLE : B_EMIT;
      end
      B_EMIT: begin
        if (out_free && (2'(idx_q) + 2'd1 == cnt_q)) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      hist_q    <= '0;
      held_q    <= '0;
      fig_q     <= 1'b0;
      cnt_q     <= '0;
      idx_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_EMIT && out_free) m_valid_q <= 1'b1;
      else if (out_ready_i)              m_valid_q <= 1'b0;
      unique case (state_q)
        B_SHIFT: begin
          hist_q <= shifted[HistBits-1:0];
          held_q <= (held_sum > 6'(HistBits)) ? 5'(HistBits) : held_sum[4:0];
          cnt_q  <= '0;
          idx_q  <= 1'b0;
        end
        B_SCAN: begin
          if (scan_go) begin
            if (frame_ok) begin
              held_q <= held_q - 5'(FrameBits);
              cnt_q  <= cnt_q + 2'd1;
              if (ch == ChFigs)      fig_q <= 1'b1;
              else if (ch == ChLtrs) fig_q <= 1'b0;
            end else begin
              held_q <= held_q - 5'd1;
            end
          end
        end
        B_EMIT: begin
          if (out_free) begin
            idx_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && !empty_i) begin
      rem_q <= run_i.ticks - {{(TickW-CfgW){1'b0}}, half};
      one_q <= run_i.mark;
      n_q   <= '0;
    end
    // ceiling divide by the bit period, one subtraction per cycle
    if (state_q == B_DIV && n_q != 5'(MaxRun)) begin
      n_q <= n_q + 5'd1;
      if (rem_q > {{(TickW-CfgW){1'b0}}, period}) begin
        rem_q <= rem_q - {{(TickW-CfgW){1'b0}}, period};
      end
    end
    if (state_q == B_SCAN && scan_go && frame_ok) begin
      res_q[cnt_q[0]] <= '{fig: fig_q, ch: ch, code: code};
    end
    if (state_q == B_EMIT && out_free) begin
      m_res_q  <= res_q[idx_q];
      m_last_q <= (2'(idx_q) + 2'd1 == cnt_q);
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_res_o   = m_res_q;
  assign out_last_o  = m_last_q;

endmodule
`default_nettype wire

FILE: bench/rtty_bit_slicer_baudot_decoder_tb.sv
`timescale 1ns / 1ps
// rtty_bit_slicer_baudot_decoder_tb: self-checking bench that drives sample words and
// checks every character word against an in-bench slicer and decoder model.
// depends on rbd_pkg and the rtty_bit_slicer_baudot_decoder rtl.
module rtty_bit_slicer_baudot_decoder_tb;
  import rbd_pkg::*;

  typedef struct packed {
    logic [4:0] code;
    logic [7:0] ch;
    logic       fig;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic        quiet;
    logic [15:0] ticks;
    logic [15:0] smp;
  } dir_row_t;

  typedef enum int {RxFree, RxCoin, RxHold} rx_mode_e;

  localparam int NumDirected  = 20;
  localparam int SettleCycles = 120;
  localparam logic [4:0] CodeFigs = 5'd27;
  localparam logic [4:0] CodeLtrs = 5'd31;

  // translation tables, entry 31 in the top byte
  localparam logic [255:0] LetterChars = {64'h8556_584D_8447_424F, 64'h5150_5948_574C_5A54,
                                          64'h4B43_464E_4A52_4483, 64'h5549_5382_4181_4580};
  localparam logic [255:0] FigureChars = {64'h853B_2F2E_8426_3F39, 64'h3130_3623_3229_2235,
                                          64'h283A_212C_8734_8683, 64'h3738_2782_2D81_3380};

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [1:0]      cfg_idx_i = RegGain;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [31:0]     s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [15:0]     m_axis_tdata;
  logic            m_axis_tlast;

  int         err_count = 0;
  int         phase_items = 0;
  int         burst_left = 0;
  int         cur_tps = 1;
  int         cur_spb = 1;
  char_word_t char_q[$];

  // model registers and state
  logic [CfgW-1:0]    p_gain, p_decay, p_period, p_switch;
  logic signed [15:0] p_level;
  logic               p_tone_mark;
  logic [31:0]        p_pending, p_mark_ticks, p_space_ticks;
  logic [15:0]        p_history;
  logic [4:0]         p_held;
  logic               p_figs;

  always #5 clk_i = ~clk_i;

  rtty_bit_slicer_baudot_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_sub32(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? a - b : 32'd0;
  endfunction

  // whole bit periods in a run, rounded to nearest, at most MaxRun
  function automatic logic [4:0] bits_in_run(input logic [31:0] t);
    longint p, h, n;
    p = (p_period == 0) ? 1 : p_period;
    h = p >> 1;
    if (longint'(t) <= h) return 5'd0;
    n = (longint'(t) - h + p - 1) / p;
    return (n > MaxRun) ? 5'(MaxRun) : 5'(n);
  endfunction

  task automatic push_bits(input logic [4:0] n, input logic one);
    logic [31:0] fill;
    int s;
    fill = one ? ((32'd1 << n) - 32'd1) : 32'd0;
    p_history = 16'(({16'h0, p_history} << n) | fill);
    s = p_held + n;
    p_held = (s > HistBits) ? 5'(HistBits) : 5'(s);
  endtask

  task automatic model_reset();
    p_gain = 15'd1024;
    p_decay = 15'd3072;
    p_period = 15'd4400;
    p_switch = 15'd1100;
    p_level = '0;
    p_tone_mark = 1'b1;
    p_pending = '0;
    p_mark_ticks = '0;
    p_space_ticks = '0;
    p_history = '0;
    p_held = '0;
    p_figs = 1'b0;
  endtask

  // filter, slice, run timing and frame search for one sample word
  task automatic decode_sample(input logic signed [15:0] smp, input logic [15:0] tk,
                               input bit keep);
    longint     dk, gk, lv, xs, lvl;
    logic       cur_mark, close_mark, close_space;
    logic [31:0] d;
    logic [15:0] w, stop_mask;
    logic [4:0] data, code;
    logic [7:0] ch;
    char_word_t got[2];
    int         count;
    dk = p_decay;
    gk = p_gain;
    lv = p_level;
    xs = smp;
    lvl = ((dk * lv) >>> FracBits) + ((gk * xs) >>> FracBits);
    if (lvl > 32767) lvl = 32767;
    else if (lvl < -32768) lvl = -32768;
    p_level = 16'(lvl);
    cur_mark = (p_level <= 0);
    close_mark = 1'b0;
    close_space = 1'b0;
    if (cur_mark == p_tone_mark) begin
      p_pending = '0;
    end else begin
      p_pending = sat_add32(p_pending, {16'h0, tk});
      if (p_pending > p_switch) begin
        // ticks spent while the new tone was pending belong to it
        d = p_pending - {16'h0, tk};
        if (p_tone_mark) begin
          p_space_ticks = d;
          p_mark_ticks = sat_sub32(p_mark_ticks, d);
          close_mark = 1'b1;
        end else begin
          p_mark_ticks = d;
          p_space_ticks = sat_sub32(p_space_ticks, d);
          close_space = 1'b1;
        end
        p_tone_mark = cur_mark;
        p_pending = '0;
      end
    end
    if (p_tone_mark) p_mark_ticks = sat_add32(p_mark_ticks, {16'h0, tk});
    else p_space_ticks = sat_add32(p_space_ticks, {16'h0, tk});
    if (close_mark) begin
      push_bits(bits_in_run(p_mark_ticks), 1'b1);
      p_mark_ticks = '0;
    end
    if (close_space) begin
      push_bits(bits_in_run(p_space_ticks), 1'b0);
      p_space_ticks = '0;
    end
    count = 0;
    stop_mask = (16'd1 << StopBits) - 16'd1;
    while (p_held >= FrameBits && count < 2) begin
      w = p_history >> (p_held - FrameBits);
      if ((w & stop_mask) == stop_mask && !w[FrameBits-1]) begin
        data = w[FrameBits-2 -: 5];
        for (int i = 0; i < 5; i++) code[4-i] = data[i];
        ch = p_figs ? FigureChars[code*8 +: 8] : LetterChars[code*8 +: 8];
        got[count] = {code, ch, p_figs, 1'b0};
        if (ch == ChFigs) p_figs = 1'b1;
        else if (ch == ChLtrs) p_figs = 1'b0;
        count++;
        p_held = p_held - 5'(FrameBits);
      end else begin
        p_held = p_held - 5'd1;
      end
    end
    if (count > 0) got[count-1].last = 1'b1;
    if (keep) begin
      for (int i = 0; i < count; i++) char_q.push_back(got[i]);
    end
  endtask

  // one sample word, sent in bursts with random gaps in between
  task automatic send_word(input logic [15:0] smp, input logic [15:0] tk, input bit keep);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tk, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    decode_sample(smp, tk, keep);
    phase_items++;
  endtask

  // one bit of tone: mark is a negative discriminator level
  task automatic tone_bit(input logic mark, input int amp);
    int a, tk;
    for (int i = 0; i < cur_spb; i++) begin
      a = amp - int'($urandom_range(0, amp / 4));
      tk = cur_tps + int'($urandom_range(0, cur_tps / 16)) - cur_tps / 32;
      if (tk > 65535) tk = 65535;
      send_word(mark ? 16'(-a) : 16'(a), 16'(tk), 1'b1);
    end
  endtask

  task automatic send_frame(input logic [4:0] code, input int amp);
    tone_bit(1'b0, amp);
    for (int i = 0; i < 5; i++) tone_bit(code[i], amp);
    repeat (StopBits) tone_bit(1'b1, amp);
    repeat ($urandom_range(0, 3)) tone_bit(1'b1, amp);
  endtask

  // wait for every expected word, then let the block finish any run in flight
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgW'(val);
    @(posedge clk_i);
    case (idx)
      RegGain:   p_gain = CfgW'(val);
      RegDecay:  p_decay = CfgW'(val);
      RegPeriod: p_period = CfgW'(val);
      RegSwitch: p_switch = CfgW'(val);
      default: ;
    endcase
  endtask

  task automatic run_phase(input int unsigned gain, decay, period, switch_dly, tps, spb,
                           quota);
    int         pick, amp;
    logic [4:0] code;
    settle();
    write_reg(RegGain, gain);
    write_reg(RegDecay, decay);
    write_reg(RegPeriod, period);
    write_reg(RegSwitch, switch_dly);
    cfg_we_i <= 1'b0;
    cur_tps = tps;
    cur_spb = spb;
    phase_items = 0;
    while (phase_items < quota) begin
      pick = $urandom_range(0, 99);
      amp = $urandom_range(1000, 32767);
      if (pick < 75) begin
        code = 5'($urandom);
        if (pick < 5) code = CodeFigs;
        else if (pick < 10) code = CodeLtrs;
        send_frame(code, amp);
      end else if (pick < 88) begin
        // frame-length run of random bits, mostly bad start or stop
        repeat (FrameBits) tone_bit($urandom_range(0, 1) == 1, amp);
      end else begin
        repeat ($urandom_range(1, 6)) send_word(16'($urandom), 16'($urandom), 1'b1);
      end
    end
  endtask

  // directed rows; quiet rows expect no word at all
  function automatic dir_row_t directed_row(input int idx);
    dir_row_t r;
    case (idx)
      0:  r = {1'b1, 16'd0,     16'h8000};
      1:  r = {1'b1, 16'hFFFF,  16'h7FFF};
      2:  r = {1'b1, 16'd0,     16'h7FFF};
      3:  r = {1'b0, 16'hFFFF,  16'h8000};
      4:  r = {1'b0, 16'hFFFF,  16'h8000};
      5:  r = {1'b0, 16'd1,     16'h0000};
      6:  r = {1'b0, 16'hFFFF,  16'hFFFF};
      7:  r = {1'b0, 16'hFFFF,  16'h7FFF};
      8:  r = {1'b0, 16'hFFFF,  16'h7FFF};
      9:  r = {1'b0, 16'd4400,  16'h0001};
      10: r = {1'b0, 16'd4400,  16'h8000};
      11: r = {1'b0, 16'd2200,  16'h8000};
      12: r = {1'b0, 16'd2201,  16'h7FFF};
      13: r = {1'b0, 16'd4400,  16'h7FFF};
      14: r = {1'b0, 16'd0,     16'h8000};
      15: r = {1'b0, 16'hFFFF,  16'h8000};
      16: r = {1'b0, 16'hFFFF,  16'h0000};
      17: r = {1'b0, 16'd1100,  16'h7FFF};
      18: r = {1'b0, 16'd1101,  16'h7FFF};
      default: r = {1'b0, 16'd8800, 16'h8000};
    endcase
    return r;
  endfunction

  rx_mode_e   rx_mode = RxFree;
  int         rx_hold = 0;
  logic [7:0] rx_tick = '0;

  always @(posedge clk_i) begin : rx_side
    char_word_t want, seen;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = {m_axis_tdata[4:0], m_axis_tdata[12:5], m_axis_tdata[13], m_axis_tlast};
      if (char_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word, expected none, actual code %h char %h fig %b last %b",
                 $time, seen.code, seen.ch, seen.fig, seen.last);
      end else begin
        want = char_q.pop_front();
        if (seen !== want || m_axis_tdata[15:14] !== 2'b00) begin
          err_count++;
          $display("%0t: expected code %h char %h fig %b last %b, actual code %h char %h fig %b last %b pad %b",
                   $time, want.code, want.ch, want.fig, want.last,
                   seen.code, seen.ch, seen.fig, seen.last, m_axis_tdata[15:14]);
        end
      end
    end
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick == 8'hFF) rx_mode <= rx_mode_e'($urandom_range(0, 2));
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RxFree: m_axis_tready <= 1'b1;
        RxCoin: m_axis_tready <= ($urandom_range(0, 1) == 1);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            rx_hold <= $urandom_range(1, 40);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin
    #20_000_000;
    $display("[rtty_bit_slicer_baudot_decoder] ERROR");
    $finish;
  end

  initial begin
    dir_row_t row;
    model_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumDirected; i++) begin
      row = directed_row(i);
      send_word(row.smp, row.ticks, !row.quiet);
    end
    //        gain   decay  period switch  tps   spb  items
    run_phase(1024,  3072,  4400,  1100,   550,  8,   300);
    run_phase(4096,  0,     300,   100,    100,  3,   260);
    run_phase(32767, 0,     32767, 0,      16383, 2,  160);
    // zero gain and zero period, filter runs on feedback alone
    run_phase(0,     32767, 0,     32767,  4000, 3,   50);
    run_phase(2048,  2048,  8,     0,      2,    4,   260);
    run_phase(3000,  1000,  1,     5,      1,    3,   100);
    run_phase(4096,  0,     32767, 32767,  6553, 5,   120);
    run_phase(4096,  0,     600,   150,    150,  4,   300);
    settle();
    if (err_count == 0) begin
      $display("[rtty_bit_slicer_baudot_decoder] OK");
    end else begin
      $display("[rtty_bit_slicer_baudot_decoder] ERROR");
    end
    $finish;
  end

endmodule

FILE: rtty_bit_slicer_baudot_decoder.f
hdl/rbd_pkg.sv
hdl/rbd_front.sv
hdl/rbd_fifo.sv
hdl/rbd_back.sv
hdl/rtty_bit_slicer_baudot_decoder.sv
bench/rtty_bit_slicer_baudot_decoder_tb.sv
